FILE: rtl/core/f0ns_pkg.sv
`timescale 1ns / 1ps

package f0ns_pkg;

  localparam int F0_W      = 20;
  localparam int FRAME_W   = 32;
  localparam int MIN_W     = 16;
  localparam int RATIO_W   = 25;
  localparam int FRAC_W    = 24;
  localparam int PROD_W    = F0_W + RATIO_W;

  localparam int MAX_NOTE_FRAMES_DEF = 256;

  localparam logic [MIN_W-1:0]   MIN_NOTE_FRAMES_RST = 16'd20;
  // 2^(80/1200) in Q1.24, rounded to nearest
  localparam logic [RATIO_W-1:0] JUMP_RATIO_Q24      = 25'd17570680;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_JMP1,
    ST_JMP2,
    ST_DECIDE,
    ST_LEN,
    ST_MEDA,
    ST_UPD,
    ST_STORE,
    ST_INS,
    ST_INS_RD,
    ST_EOS,
    ST_MEDB
  } f0ns_state_t;

endpackage

FILE: rtl/core/f0ns_in_if.sv
`timescale 1ns / 1ps

interface f0ns_in_if;
  logic                       valid;
  logic                       ready;
  logic [f0ns_pkg::F0_W-1:0]  f0_value;
  logic                       end_of_stream;

  modport source (output valid, output f0_value, output end_of_stream, input ready);
  modport sink   (input valid, input f0_value, input end_of_stream, output ready);
endinterface

FILE: rtl/core/f0ns_out_if.sv
`timescale 1ns / 1ps

interface f0ns_out_if;
  logic                          valid;
  logic                          ready;
  logic [f0ns_pkg::FRAME_W-1:0]  start_frame;
  logic [f0ns_pkg::FRAME_W-1:0]  end_frame;
  logic [f0ns_pkg::F0_W-1:0]     note_pitch;
  logic                          truncated;
  logic                          last_of_run;

  modport source (output valid, output start_frame, output end_frame, output note_pitch,
                  output truncated, output last_of_run, input ready);
  modport sink   (input valid, input start_frame, input end_frame, input note_pitch,
                  input truncated, input last_of_run, output ready);
endinterface

FILE: rtl/core/f0_note_segmenter_unit.sv
`timescale 1ns / 1ps
// Each frame runs through the jump check, the note decision, the median read for a closing
// note, the update and the store; a voiced pitch is placed by a sorted insert that moves each
// larger stored pitch up one place, and a note closed by end of stream adds a median read.
// One frame is taken at a time: input is accepted only in idle, after the insert loop; a held
// result beat stalls the frame that closes a note until the beat is taken.
// Reset (rst_n low, synchronous): no open note, frame index zero, min_note_frames = 20.

module f0_note_segmenter_unit #(
  parameter int MAX_NOTE_FRAMES = f0ns_pkg::MAX_NOTE_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  f0ns_in_if.sink                      in_ch,
  f0ns_out_if.source                   out_ch,
  input  logic                         cfg_wr_en,
  input  logic [f0ns_pkg::MIN_W-1:0]   cfg_wr_data
);

  localparam int IW = $clog2(MAX_NOTE_FRAMES);
  localparam int CW = $clog2(MAX_NOTE_FRAMES + 1);

  localparam int F0_W    = f0ns_pkg::F0_W;
  localparam int FRAME_W = f0ns_pkg::FRAME_W;
  localparam int MIN_W   = f0ns_pkg::MIN_W;
  localparam int PROD_W  = f0ns_pkg::PROD_W;
  localparam int FRAC_W  = f0ns_pkg::FRAC_W;

  f0ns_pkg::f0ns_state_t state_r, state_nxt;

  logic [MIN_W-1:0]   min_r;
  logic [FRAME_W-1:0] frame_index_r;
  logic               in_note_r;
  logic [FRAME_W-1:0] note_start_r;
  logic [F0_W-1:0]    prev_r;
  logic [CW-1:0]      count_r;
  logic               ovf_r;

  logic [F0_W-1:0]    v_r;
  logic               eos_r;
  logic [FRAME_W-1:0] idx_r;
  logic [FRAME_W-1:0] idx_p1_r;
  logic [PROD_W-1:0]  prod_r;
  logic               ge_a_r;
  logic               close_a_r;
  logic [FRAME_W-1:0] new_start_r;
  logic               a_emit_r;
  logic               b_emit_r;
  logic [IW-1:0]      pos_r;

  logic [F0_W-1:0]    pitch_mem [MAX_NOTE_FRAMES];
  logic [F0_W-1:0]    rd_data_r;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [F0_W-1:0]    mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;

  logic               out_valid_r;
  logic [FRAME_W-1:0] out_start_r;
  logic [FRAME_W-1:0] out_end_r;
  logic [F0_W-1:0]    out_pitch_r;
  logic               out_trunc_r;
  logic               out_last_r;

  logic               out_free;
  logic               out_load;
  logic [FRAME_W-1:0] load_end;
  logic               load_last;
  logic               accept;
  logic               close_a_w;
  logic               store_full;
  logic               shift_w;
  logic [IW-1:0]      med_addr;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign accept     = in_ch.valid && in_ch.ready;
  assign store_full = (count_r >= CW'(MAX_NOTE_FRAMES));
  assign shift_w    = (rd_data_r > v_r);
  assign med_addr   = IW'(count_r >> 1);
  assign close_a_w  = in_note_r && ((v_r == '0) ||
                      ((prev_r != '0) &&
                       (ge_a_r || ({1'b0, prev_r, {FRAC_W{1'b0}}} >= prod_r))));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      f0ns_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = f0ns_pkg::ST_JMP1;
      f0ns_pkg::ST_JMP1:   state_nxt = f0ns_pkg::ST_JMP2;
      f0ns_pkg::ST_JMP2:   state_nxt = f0ns_pkg::ST_DECIDE;
      f0ns_pkg::ST_DECIDE: state_nxt = f0ns_pkg::ST_LEN;
      f0ns_pkg::ST_LEN:    state_nxt = f0ns_pkg::ST_MEDA;
      f0ns_pkg::ST_MEDA:   if (!a_emit_r || out_free) state_nxt = f0ns_pkg::ST_UPD;
      f0ns_pkg::ST_UPD:    state_nxt = f0ns_pkg::ST_STORE;
      f0ns_pkg::ST_STORE: begin
        if (v_r == '0 || store_full || count_r == '0) state_nxt = f0ns_pkg::ST_EOS;
        else                                          state_nxt = f0ns_pkg::ST_INS;
      end
      f0ns_pkg::ST_INS:    state_nxt = shift_w ? f0ns_pkg::ST_INS_RD : f0ns_pkg::ST_EOS;
      f0ns_pkg::ST_INS_RD: state_nxt = (pos_r == '0) ? f0ns_pkg::ST_EOS : f0ns_pkg::ST_INS;
      f0ns_pkg::ST_EOS:    state_nxt = b_emit_r ? f0ns_pkg::ST_MEDB : f0ns_pkg::ST_IDLE;
      f0ns_pkg::ST_MEDB:   if (out_free) state_nxt = f0ns_pkg::ST_IDLE;
      default:             state_nxt = f0ns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = v_r;
    mem_re      = 1'b0;
    mem_raddr   = med_addr;
    out_load    = 1'b0;
    load_end    = idx_r;
    load_last   = 1'b1;
    unique case (state_r)
      f0ns_pkg::ST_IDLE: in_ch.ready = 1'b1;
      f0ns_pkg::ST_LEN:  mem_re = 1'b1;
      f0ns_pkg::ST_MEDA: begin
        out_load  = a_emit_r && out_free;
        load_last = !b_emit_r;
      end
      f0ns_pkg::ST_STORE: begin
        if (v_r != '0 && !store_full) begin
          if (count_r == '0) begin
            mem_we = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IW'(count_r - CW'(1));
          end
        end
      end
      f0ns_pkg::ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = shift_w ? rd_data_r : v_r;
      end
      f0ns_pkg::ST_INS_RD: begin
        if (pos_r == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_r - IW'(1);
        end
      end
      f0ns_pkg::ST_EOS:  mem_re = b_emit_r;
      f0ns_pkg::ST_MEDB: begin
        out_load = out_free;
        load_end = idx_p1_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) pitch_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= pitch_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= f0ns_pkg::ST_IDLE;
      min_r         <= f0ns_pkg::MIN_NOTE_FRAMES_RST;
      frame_index_r <= '0;
      in_note_r     <= 1'b0;
      note_start_r  <= '0;
      prev_r        <= '0;
      count_r       <= '0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) min_r <= cfg_wr_data;
      if (out_load)                out_valid_r <= 1'b1;
      else if (out_ch.ready)       out_valid_r <= 1'b0;
      unique case (state_r)
        f0ns_pkg::ST_UPD: begin
          if (v_r != '0 && (close_a_r || !in_note_r)) begin
            in_note_r    <= 1'b1;
            note_start_r <= idx_r;
            count_r      <= '0;
            ovf_r        <= 1'b0;
          end else if (close_a_r) begin
            in_note_r <= 1'b0;
            count_r   <= '0;
            ovf_r     <= 1'b0;
          end
          prev_r <= v_r;
        end
        f0ns_pkg::ST_STORE: begin
          if (v_r != '0) begin
            if (store_full)          ovf_r   <= 1'b1;
            else if (count_r == '0)  count_r <= count_r + CW'(1);
          end
        end
        f0ns_pkg::ST_INS:    if (!shift_w) count_r <= count_r + CW'(1);
        f0ns_pkg::ST_INS_RD: if (pos_r == '0) count_r <= count_r + CW'(1);
        f0ns_pkg::ST_EOS: begin
          frame_index_r <= eos_r ? '0 : idx_p1_r;
          if (eos_r) prev_r <= '0;
          if (eos_r && !b_emit_r) begin
            in_note_r <= 1'b0;
            count_r   <= '0;
            ovf_r     <= 1'b0;
          end
        end
        f0ns_pkg::ST_MEDB: begin
          if (out_free) begin
            in_note_r <= 1'b0;
            count_r   <= '0;
            ovf_r     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_r   <= in_ch.f0_value;
      eos_r <= in_ch.end_of_stream;
      idx_r <= frame_index_r;
    end
    unique case (state_r)
      f0ns_pkg::ST_JMP1: begin
        prod_r   <= PROD_W'(prev_r) * PROD_W'(f0ns_pkg::JUMP_RATIO_Q24);
        idx_p1_r <= idx_r + FRAME_W'(1);
      end
      f0ns_pkg::ST_JMP2: begin
        ge_a_r <= ({1'b0, v_r, {FRAC_W{1'b0}}} >= prod_r);
        prod_r <= PROD_W'(v_r) * PROD_W'(f0ns_pkg::JUMP_RATIO_Q24);
      end
      f0ns_pkg::ST_DECIDE: begin
        close_a_r   <= close_a_w;
        new_start_r <= (v_r != '0 && (!in_note_r || close_a_w)) ? idx_r : note_start_r;
      end
      f0ns_pkg::ST_LEN: begin
        a_emit_r <= close_a_r && (count_r != '0) &&
                    ((idx_r - note_start_r) >= FRAME_W'(min_r));
        b_emit_r <= eos_r && (v_r != '0) &&
                    ((idx_p1_r - new_start_r) >= FRAME_W'(min_r));
      end
      f0ns_pkg::ST_STORE: pos_r <= IW'(count_r);
      f0ns_pkg::ST_INS:   if (shift_w) pos_r <= pos_r - IW'(1);
      default: ;
    endcase
    if (out_load) begin
      out_start_r <= note_start_r;
      out_end_r   <= load_end;
      out_pitch_r <= rd_data_r;
      out_trunc_r <= ovf_r;
      out_last_r  <= load_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.start_frame = out_start_r;
  assign out_ch.end_frame   = out_end_r;
  assign out_ch.note_pitch  = out_pitch_r;
  assign out_ch.truncated   = out_trunc_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

FILE: rtl/core/f0ns_chk.sv
`timescale 1ns / 1ps

module f0ns_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [f0ns_pkg::FRAME_W-1:0]  out_start_frame,
  input logic [f0ns_pkg::FRAME_W-1:0]  out_end_frame,
  input logic [f0ns_pkg::F0_W-1:0]     out_note_pitch,
  input logic                          out_truncated,
  input logic                          out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_frame) &&
      $stable(out_end_frame) && $stable(out_note_pitch) &&
      $stable(out_truncated) && $stable(out_last_of_run))
    else $error("result beat changed while stalled");

  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame taken before the first finished");

  a_pitch_voiced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_note_pitch != '0)
    else $error("note with unvoiced pitch");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind f0_note_segmenter_unit f0ns_chk u_f0ns_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_start_frame (out_ch.start_frame),
  .out_end_frame   (out_ch.end_frame),
  .out_note_pitch  (out_ch.note_pitch),
  .out_truncated   (out_ch.truncated),
  .out_last_of_run (out_ch.last_of_run)
);

FILE: tb/sv/f0_note_segmenter_unit_tb.sv
`timescale 1ns / 1ps

module f0_note_segmenter_unit_tb;

  localparam int F0_W    = f0ns_pkg::F0_W;
  localparam int FRAME_W = f0ns_pkg::FRAME_W;
  localparam int MIN_W   = f0ns_pkg::MIN_W;

  localparam int STORE_DEPTH = f0ns_pkg::MAX_NOTE_FRAMES_DEF;
  localparam int DRAIN_CYCLES = 2 * STORE_DEPTH + 10 + 64;
  localparam int SETTLE_LIMIT = 200000;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [63:0] RATIO_Q24 = 64'd17570680;

  typedef struct packed {
    logic [FRAME_W-1:0] start_frame;
    logic [FRAME_W-1:0] end_frame;
    logic [F0_W-1:0]    note_pitch;
    logic               truncated;
    logic               last_of_run;
  } note_t;

  typedef enum {ROW_FRAME, ROW_MIN} row_kind_t;

  // ROW_MIN rows carry the register value in f0[15:0]
  typedef struct {
    row_kind_t       kind;
    logic [F0_W-1:0] f0;
    logic            eos;
    int              n_typed;
    note_t           typed;
  } row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SHUT, RX_SPARSE} rx_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [MIN_W-1:0] cfg_wr_data;

  f0ns_in_if  in_ch();
  f0ns_out_if out_ch();

  f0_note_segmenter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [MIN_W-1:0]   min_frames;
  logic [FRAME_W-1:0] frame_idx;
  logic [FRAME_W-1:0] note_start;
  logic               in_note;
  logic               ovf;
  logic [F0_W-1:0]    prev_voiced;
  logic [F0_W-1:0]    pitch_store [STORE_DEPTH];
  int                 pitch_cnt;

  note_t step_notes [$];
  note_t pending_notes [$];
  row_t  dir_rows [$];

  int errors = 0;
  int frames_sent = 0;
  int notes_checked = 0;
  int trunc_seen = 0;
  int pair_runs = 0;
  int min_writes = 0;
  int burst_left = 0;
  int cycles = 0;
  bit hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_jump(logic [F0_W-1:0] v, logic [F0_W-1:0] prev);
    logic [63:0] a, b, c, d;
    a = {44'd0, v} << 24;
    b = {44'd0, prev} * RATIO_Q24;
    c = {44'd0, prev} << 24;
    d = {44'd0, v} * RATIO_Q24;
    return (a >= b) || (c >= d);
  endfunction

  task automatic close_note(input logic [FRAME_W-1:0] end_at);
    logic [FRAME_W-1:0] len;
    note_t nt;
    len = end_at - note_start;
    if (len >= {16'd0, min_frames} && pitch_cnt > 0 && step_notes.size() < 2) begin
      nt.start_frame = note_start;
      nt.end_frame   = end_at;
      nt.note_pitch  = pitch_store[(pitch_cnt / 2) % STORE_DEPTH];
      nt.truncated   = ovf;
      nt.last_of_run = 1'b0;
      if (nt.note_pitch != '0) step_notes.insert(step_notes.size(), nt);
    end
    in_note   = 1'b0;
    pitch_cnt = 0;
    ovf       = 1'b0;
  endtask

  task automatic predict_frame(input logic [F0_W-1:0] f0, input logic eos);
    logic [FRAME_W-1:0] idx;
    int pos;
    step_notes.delete();
    idx = frame_idx;
    if (f0 == '0) begin
      if (in_note) close_note(idx);
      prev_voiced = '0;
    end else begin
      if (!in_note) begin
        in_note = 1'b1; note_start = idx; pitch_cnt = 0; ovf = 1'b0;
      end else if (prev_voiced != '0 && is_jump(f0, prev_voiced)) begin
        close_note(idx);
        in_note = 1'b1; note_start = idx; pitch_cnt = 0; ovf = 1'b0;
      end
      if (pitch_cnt >= STORE_DEPTH) begin
        ovf = 1'b1;
      end else begin
        pos = pitch_cnt;
        while (pos > 0 && pitch_store[pos-1] > f0) begin
          pitch_store[pos] = pitch_store[pos-1];
          pos--;
        end
        pitch_store[pos] = f0;
        pitch_cnt++;
      end
      prev_voiced = f0;
    end
    frame_idx = idx + 1;
    if (eos) begin
      if (in_note) close_note(frame_idx);
      frame_idx   = '0;
      prev_voiced = '0;
    end
    if (step_notes.size() > 0) step_notes[step_notes.size()-1].last_of_run = 1'b1;
  endtask

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_frame(input logic [F0_W-1:0] f0, input logic eos,
                            input int n_typed, input note_t typed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid         = 1'b1;
    in_ch.f0_value      = f0;
    in_ch.end_of_stream = eos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_frame(f0, eos);
    if (n_typed < 0) begin
      foreach (step_notes[k]) pending_notes.insert(pending_notes.size(), step_notes[k]);
    end else if (n_typed > 0) begin
      pending_notes.insert(pending_notes.size(), typed);
    end
    if (step_notes.size() == 2) pair_runs++;
    frames_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_min(input logic [MIN_W-1:0] v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en  = 1'b0;
    min_frames = v;
    min_writes++;
  endtask

  task automatic settle();
    int waited;
    in_ch.valid = 1'b0;
    waited = 0;
    while (pending_notes.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_notes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected notes never arrived", $time, pending_notes.size());
      pending_notes.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [F0_W-1:0] f0, input logic eos,
                         input int n_typed, input note_t typed);
    row_t row;
    row.kind    = kind;
    row.f0      = f0;
    row.eos     = eos;
    row.n_typed = n_typed;
    row.typed   = typed;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic logic [F0_W-1:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return F0_W'($urandom_range(1, 255));
      1:       return F0_W'($urandom_range(256, 65535));
      default: return F0_W'($urandom_range(65536, 1000000));
    endcase
  endfunction

  // stays well inside the jump ratio of the previous frame
  function automatic logic [F0_W-1:0] near(logic [F0_W-1:0] base);
    int unsigned span, val;
    span = base >> 7;
    val  = base - span + $urandom_range(0, 2 * span);
    return val[F0_W-1:0];
  endfunction

  task automatic run_phase(input int n_items, input logic [MIN_W-1:0] min_val,
                           input bit long_first, input bit with_hold);
    int target, len, gap, i;
    logic [F0_W-1:0] base;
    bit eos;
    settle();
    write_min(min_val);
    if (with_hold) hold_req = 1'b1;
    target = frames_sent + n_items;
    if (long_first) begin
      base = pick_base();
      len  = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 24);
      for (i = 0; i < len; i++) send_frame(near(base), 1'b0, -1, '0);
      send_frame('0, 1'b0, -1, '0);
    end
    while (frames_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_frame(F0_W'($urandom()), $urandom_range(0, 15) == 0, -1, '0);
      end else begin
        len  = ($urandom_range(0, 79) == 0) ? $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8)
                                            : $urandom_range(1, 45);
        base = pick_base();
        eos  = ($urandom_range(0, 5) == 0);
        for (i = 0; i < len; i++) begin
          if (i > 0 && $urandom_range(0, 29) == 0) base = pick_base();
          send_frame(near(base), eos && (i == len - 1), -1, '0);
        end
        if (!eos) begin
          gap = $urandom_range(0, 3);
          repeat (gap) send_frame('0, $urandom_range(0, 19) == 0, -1, '0);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, exp, act);
    end
  endtask

  initial begin
    note_t exp;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_notes.size() == 0) begin
          errors++;
          $display("%0t: unexpected note beat start %h end %h pitch %h", $time,
                   out_ch.start_frame, out_ch.end_frame, out_ch.note_pitch);
        end else begin
          exp = pending_notes.pop_front();
          check_field("start_frame", exp.start_frame, out_ch.start_frame);
          check_field("end_frame", exp.end_frame, out_ch.end_frame);
          check_field("note_pitch", 32'(exp.note_pitch), 32'(out_ch.note_pitch));
          check_field("truncated", 32'(exp.truncated), 32'(out_ch.truncated));
          check_field("last_of_run", 32'(exp.last_of_run), 32'(out_ch.last_of_run));
          notes_checked++;
          if (out_ch.truncated === 1'b1) trunc_seen++;
        end
      end
    end
  end

  initial begin
    rx_mode_t mode;
    int run_left, hold_left;
    out_ch.ready = 1'b0;
    mode      = RX_OPEN;
    run_left  = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready = 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(5, 120);
        end
        run_left--;
        case (mode)
          RX_OPEN: out_ch.ready = 1'b1;
          RX_COIN: out_ch.ready = 1'($urandom_range(0, 1));
          RX_SHUT: out_ch.ready = 1'b0;
          default: out_ch.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int r;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.f0_value      = '0;
    in_ch.end_of_stream = 1'b0;
    min_frames  = 16'd20;
    frame_idx   = '0;
    note_start  = '0;
    in_note     = 1'b0;
    ovf         = 1'b0;
    prev_voiced = '0;
    pitch_cnt   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // short note under the reset minimum
    add_row(ROW_FRAME, 20'hFFFFF, 1'b1, 0, '0);
    add_row(ROW_MIN, 20'd1, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'hFFFFF, 1'b1, 1, '{32'd0, 32'd1, 20'hFFFFF, 1'b0, 1'b1});
    add_row(ROW_FRAME, 20'd1, 1'b1, 1, '{32'd0, 32'd1, 20'd1, 1'b0, 1'b1});
    add_row(ROW_FRAME, 20'd0, 1'b1, 0, '0);
    add_row(ROW_FRAME, 20'd256, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd300, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd290, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd0, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd1000, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd1000, 1'b1, -1, '0);
    // jump on the end-of-stream frame: two notes in one run
    add_row(ROW_FRAME, 20'd5000, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd10000, 1'b1, -1, '0);
    add_row(ROW_FRAME, 20'd10000, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd9000, 1'b0, -1, '0);
    // just under and just at the jump ratio
    add_row(ROW_FRAME, 20'd100000, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd104729, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd100000, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd104730, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd0, 1'b1, -1, '0);
    add_row(ROW_MIN, 20'd0, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd777, 1'b1, 1, '{32'd0, 32'd1, 20'd777, 1'b0, 1'b1});
    add_row(ROW_MIN, 20'd65535, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd777, 1'b0, -1, '0);
    add_row(ROW_FRAME, 20'd0, 1'b1, 0, '0);
    add_row(ROW_FRAME, 20'd12345, 1'b1, 0, '0);

    @(negedge clk);
    for (r = 0; r < dir_rows.size(); r++) begin
      if (dir_rows[r].kind == ROW_MIN) begin
        settle();
        write_min(dir_rows[r].f0[MIN_W-1:0]);
      end else begin
        send_frame(dir_rows[r].f0, dir_rows[r].eos, dir_rows[r].n_typed, dir_rows[r].typed);
      end
    end

    run_phase(230, 16'd2, 1'b0, 1'b0);
    run_phase(230, 16'd20, 1'b1, 1'b0);
    run_phase(230, 16'd1, 1'b0, 1'b1);
    run_phase(230, 16'd0, 1'b1, 1'b0);
    run_phase(230, 16'd9, 1'b0, 1'b0);
    settle();

    $display("%0d frames over %0d min_note_frames writes, %0d notes compared",
             frames_sent, min_writes, notes_checked);
    $display("%0d truncated notes, %0d frames closing two notes, one %0d-cycle receiver hold",
             trunc_seen, pair_runs, HOLD_CYCLES);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/f0ns_pkg.sv
rtl/core/f0ns_in_if.sv
rtl/core/f0ns_out_if.sv
rtl/core/f0_note_segmenter_unit.sv
rtl/core/f0ns_chk.sv
tb/sv/f0_note_segmenter_unit_tb.sv
